[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the spiral scan block.
// Depends on nothing; each user provides clk and rst_n in its scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define SMOS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression that must never be true outside reset.
`define SMOS_NEVER(lbl, expr, msg) \
  `SMOS_ASSERT(lbl, !(expr), msg)

`endif

[rtl/smos_pkg.sv]
// Shared types, constants and helper functions for the spiral scan block.
// Depends on nothing; used by every module in rtl.
package smos_pkg;

  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLS    = 8;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int DATA_W      = 32;
  localparam int DIM_W       = 4;
  localparam int POS_W       = $clog2(MAX_ROWS > MAX_COLS ? MAX_ROWS : MAX_COLS);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // Register index, taken from paddr[2].
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  typedef enum logic [2:0] {
    WK_IDLE,
    WK_RIGHT,
    WK_DOWN,
    WK_LEFT,
    WK_UP
  } walk_state_t;

  // Read request from the walker to the store.
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  // Zero counts as one, anything above the limit counts as the limit.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > lim) begin
      r = lim;
    end
    return r;
  endfunction

endpackage

[rtl/spiral_order_matrix_scan.sv]
// Top level of the spiral scan block: configuration registers, load counter,
// element store and spiral walker. Uses smos_pkg, smos_store, smos_walk.
//
// Usage. Program row_count (address 0) and col_count (address 4) over the
// APB-style port while the block is idle; a count of zero acts as one and a
// count above eight acts as eight. Any register write restarts loading.
// Then present the matrix elements in row-major order: each element is taken
// at a clock edge with start high and busy low. Elements can be taken back
// to back, and loading raises no result.
// The edge that takes the final element launches the spiral. From the next
// cycle busy is high while the walker reads one store entry per cycle, until
// every element has been read. Each item appears on out_value with out_strobe
// for exactly one cycle, in the cycle after its read, and the last item of the
// spiral carries out_last. The first result leaves through the walker's state
// register and the store's read register after the final element is taken.
// The receiver cannot stall: every strobed item must be taken when shown.
// Reset sets both counts to eight and empties the load counter; the store
// needs no clearing because the spiral only reads entries loaded before it.
module spiral_order_matrix_scan (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input items.
  input  logic                               start,
  output logic                               busy,
  input  logic signed [smos_pkg::DATA_W-1:0] in_element,
  // Result items.
  output logic                               out_strobe,
  output logic signed [smos_pkg::DATA_W-1:0] out_value,
  output logic                               out_last,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [smos_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [smos_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [smos_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import smos_pkg::*;
  `include "assert_macros.svh"

  logic [DIM_W-1:0]   row_count_r, row_count_nxt;
  logic [DIM_W-1:0]   col_count_r, col_count_nxt;
  logic [CNT_W-1:0]   load_cnt_r, load_cnt_nxt;
  logic [DIM_W-1:0]   rows_eff, cols_eff;
  logic [CNT_W-1:0]   total;
  logic               cfg_wr;
  logic               accept;
  logic               go;
  logic               walk_busy;
  rd_req_t            rd;
  logic [DATA_W-1:0]  rdata;
  logic               strobe_r, last_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Registers are 4 bits wide; paddr[2] picks the register.
  always_comb begin
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_ROW_COUNT: row_count_nxt = pwdata[DIM_W-1:0];
        REG_COL_COUNT: col_count_nxt = pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROW_COUNT: prdata = CFG_DATA_W'(row_count_r);
      REG_COL_COUNT: prdata = CFG_DATA_W'(col_count_r);
      default:       prdata = '0;
    endcase
  end

  assign rows_eff = clamp_dim(row_count_r, DIM_W'(MAX_ROWS));
  assign cols_eff = clamp_dim(col_count_r, DIM_W'(MAX_COLS));
  assign total    = CNT_W'(rows_eff) * CNT_W'(cols_eff);

  // The element that fills the matrix launches the walk and rewinds loading.
  assign busy   = walk_busy;
  assign accept = start && !busy;
  assign go     = accept && (load_cnt_r + CNT_W'(1) == total);

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    priority if (cfg_wr) begin
      load_cnt_nxt = '0;
    end else if (go) begin
      load_cnt_nxt = '0;
    end else if (accept) begin
      load_cnt_nxt = load_cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= DIM_W'(MAX_ROWS);
      col_count_r <= DIM_W'(MAX_COLS);
      load_cnt_r  <= '0;
      strobe_r    <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
      load_cnt_r  <= load_cnt_nxt;
      strobe_r    <= rd.valid;
      last_r      <= rd.last;
    end
  end

  // Loads and spiral reads never overlap on the same entry: the walk starts
  // after the final write, and loads are refused while it runs.
  smos_store u_store (
    .clk   (clk),
    .we    (accept),
    .waddr (load_cnt_r[ADDR_W-1:0]),
    .wdata (in_element),
    .re    (rd.valid),
    .raddr (rd.addr),
    .rdata (rdata)
  );

  smos_walk u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .rows  (rows_eff),
    .cols  (cols_eff),
    .rd    (rd),
    .busy  (walk_busy)
  );

  assign out_strobe = strobe_r;
  assign out_value  = rdata;
  assign out_last   = last_r;

  `SMOS_ASSERT(a_load_below_total, load_cnt_r < total,
    "load counter reached the matrix size without launching the spiral")
  `SMOS_ASSERT(a_last_then_quiet, out_last |=> !out_strobe,
    "result strobe continued after the last item")
  `SMOS_NEVER(a_last_needs_strobe, out_last && !out_strobe,
    "last flag shown without a result")

endmodule

[rtl/smos_store.sv]
// Element store of the spiral scan: 64 x 32 synchronous RAM.
// One write port and one read port, read data registered; uses smos_pkg.
module smos_store (
  input  logic                          clk,
  input  logic                          we,
  input  logic [smos_pkg::ADDR_W-1:0]   waddr,
  input  logic [smos_pkg::DATA_W-1:0]   wdata,
  input  logic                          re,
  input  logic [smos_pkg::ADDR_W-1:0]   raddr,
  output logic [smos_pkg::DATA_W-1:0]   rdata
);
  import smos_pkg::*;

  logic [DATA_W-1:0] mem [STORE_DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/smos_walk.sv]
// Spiral address walker: steps through the stored matrix ring by ring and
// issues one store read a cycle. Uses smos_pkg and assert_macros.svh.
module smos_walk (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [smos_pkg::DIM_W-1:0]  rows,
  input  logic [smos_pkg::DIM_W-1:0]  cols,
  output smos_pkg::rd_req_t           rd,
  output logic                        busy
);
  import smos_pkg::*;
  `include "assert_macros.svh"

  walk_state_t       state_r, state_nxt;
  logic [POS_W-1:0]  row_r, row_nxt, col_r, col_nxt;
  logic [POS_W-1:0]  top_r, top_nxt, bottom_r, bottom_nxt;
  logic [POS_W-1:0]  left_r, left_nxt, right_r, right_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [DIM_W-1:0]  cols_r, cols_nxt;
  logic [CNT_W-1:0]  left_cnt_r, left_cnt_nxt;
  logic [2*DIM_W-1:0] total;
  logic              final_step;

  assign total      = rows * cols;
  assign final_step = (left_cnt_r == CNT_W'(1));

  // Next state: the walk turns at each bound and stops after the last element.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      WK_IDLE:  if (go) state_nxt = WK_RIGHT;
      WK_RIGHT: begin
        if (final_step) state_nxt = WK_IDLE;
        else if (col_r == right_r) state_nxt = WK_DOWN;
      end
      WK_DOWN: begin
        if (final_step) state_nxt = WK_IDLE;
        else if (row_r == bottom_r) state_nxt = WK_LEFT;
      end
      WK_LEFT: begin
        if (final_step) state_nxt = WK_IDLE;
        else if (col_r == left_r) state_nxt = WK_UP;
      end
      WK_UP: begin
        if (final_step) state_nxt = WK_IDLE;
        else if (row_r == top_r) state_nxt = WK_RIGHT;
      end
      default: state_nxt = WK_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    busy     = (state_r != WK_IDLE);
    rd.valid = (state_r != WK_IDLE);
    rd.last  = (state_r != WK_IDLE) && final_step;
    rd.addr  = addr_r;
  end

  // Position, bounds and linear address. A turn shrinks the bound just walked.
  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    top_nxt      = top_r;
    bottom_nxt   = bottom_r;
    left_nxt     = left_r;
    right_nxt    = right_r;
    addr_nxt     = addr_r;
    cols_nxt     = cols_r;
    left_cnt_nxt = left_cnt_r;
    unique case (state_r)
      WK_IDLE: begin
        if (go) begin
          row_nxt      = '0;
          col_nxt      = '0;
          top_nxt      = '0;
          left_nxt     = '0;
          bottom_nxt   = POS_W'(rows - DIM_W'(1));
          right_nxt    = POS_W'(cols - DIM_W'(1));
          addr_nxt     = '0;
          cols_nxt     = cols;
          left_cnt_nxt = CNT_W'(total);
        end
      end
      WK_RIGHT: begin
        left_cnt_nxt = left_cnt_r - CNT_W'(1);
        if (col_r != right_r) begin
          col_nxt  = col_r + POS_W'(1);
          addr_nxt = addr_r + ADDR_W'(1);
        end else begin
          top_nxt  = top_r + POS_W'(1);
          row_nxt  = row_r + POS_W'(1);
          addr_nxt = addr_r + ADDR_W'(cols_r);
        end
      end
      WK_DOWN: begin
        left_cnt_nxt = left_cnt_r - CNT_W'(1);
        if (row_r != bottom_r) begin
          row_nxt  = row_r + POS_W'(1);
          addr_nxt = addr_r + ADDR_W'(cols_r);
        end else begin
          right_nxt = right_r - POS_W'(1);
          col_nxt   = col_r - POS_W'(1);
          addr_nxt  = addr_r - ADDR_W'(1);
        end
      end
      WK_LEFT: begin
        left_cnt_nxt = left_cnt_r - CNT_W'(1);
        if (col_r != left_r) begin
          col_nxt  = col_r - POS_W'(1);
          addr_nxt = addr_r - ADDR_W'(1);
        end else begin
          bottom_nxt = bottom_r - POS_W'(1);
          row_nxt    = row_r - POS_W'(1);
          addr_nxt   = addr_r - ADDR_W'(cols_r);
        end
      end
      WK_UP: begin
        left_cnt_nxt = left_cnt_r - CNT_W'(1);
        if (row_r != top_r) begin
          row_nxt  = row_r - POS_W'(1);
          addr_nxt = addr_r - ADDR_W'(cols_r);
        end else begin
          left_nxt = left_r + POS_W'(1);
          col_nxt  = col_r + POS_W'(1);
          addr_nxt = addr_r + ADDR_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= WK_IDLE;
      left_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      left_cnt_r <= left_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    top_r    <= top_nxt;
    bottom_r <= bottom_nxt;
    left_r   <= left_nxt;
    right_r  <= right_nxt;
    addr_r   <= addr_nxt;
    cols_r   <= cols_nxt;
  end

  `SMOS_ASSERT(a_addr_tracks_pos,
    busy |-> (addr_r == ADDR_W'(ADDR_W'(row_r) * ADDR_W'(cols_r) + ADDR_W'(col_r))),
    "walker address does not match its row and column")
  `SMOS_ASSERT(a_pos_in_ring,
    busy |-> (row_r >= top_r && row_r <= bottom_r && col_r >= left_r && col_r <= right_r),
    "walker left the current ring")
  `SMOS_ASSERT(a_last_ends_walk, rd.last |=> !busy,
    "walker kept reading after the last element")

endmodule

[tb/sv/spiral_scan_checker.sv]
// Checker for the spiral scan block: predicts the spiral from the loaded items
// and compares every strobed result. Depends on smos_pkg for widths and codes.
`timescale 1ns / 100ps

module spiral_scan_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic signed [smos_pkg::DATA_W-1:0] in_element,
  input  logic                               out_strobe,
  input  logic signed [smos_pkg::DATA_W-1:0] out_value,
  input  logic                               out_last,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [smos_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [smos_pkg::CFG_DATA_W-1:0]    pwdata,
  input  logic                               pready,
  output int                                 err_count,
  output int                                 pending,
  output int                                 results_seen,
  output int                                 spirals_done
);
  import smos_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } spiral_result_t;

  logic [DIM_W-1:0]         row_reg;
  logic [DIM_W-1:0]         col_reg;
  logic signed [DATA_W-1:0] fill_store [STORE_DEPTH];
  int                       fill_count;
  spiral_result_t           spiral_expect_q [$];
  spiral_result_t           head;

  function automatic int eff_dim(input logic [DIM_W-1:0] v, input int lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  // Rings from the outside in; a lone row or column is walked only once.
  function automatic void walk_spiral();
    int rows, cols, top_r, bot_r, lft_c, rgt_c, i, k;
    int idx_q [$];
    spiral_result_t r;
    rows  = eff_dim(row_reg, MAX_ROWS);
    cols  = eff_dim(col_reg, MAX_COLS);
    top_r = 0;
    bot_r = rows - 1;
    lft_c = 0;
    rgt_c = cols - 1;
    while (lft_c <= rgt_c && top_r <= bot_r) begin
      for (i = lft_c; i <= rgt_c; i++) idx_q.insert(idx_q.size(), top_r * cols + i);
      for (i = top_r + 1; i <= bot_r; i++) idx_q.insert(idx_q.size(), i * cols + rgt_c);
      if (top_r != bot_r) begin
        for (i = rgt_c - 1; i >= lft_c; i--) begin
          idx_q.insert(idx_q.size(), bot_r * cols + i);
        end
      end
      if (lft_c != rgt_c) begin
        for (i = bot_r - 1; i >= top_r + 1; i--) begin
          idx_q.insert(idx_q.size(), i * cols + lft_c);
        end
      end
      top_r++;
      bot_r--;
      lft_c++;
      rgt_c--;
    end
    for (k = 0; k < idx_q.size(); k++) begin
      r.value = fill_store[idx_q[k]];
      r.last  = (k == idx_q.size() - 1);
      spiral_expect_q.insert(spiral_expect_q.size(), r);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      row_reg      = DIM_W'(MAX_ROWS);
      col_reg      = DIM_W'(MAX_COLS);
      fill_count   = 0;
      err_count    = 0;
      results_seen = 0;
      spirals_done = 0;
      spiral_expect_q.delete();
    end else begin
      if (out_strobe) begin
        results_seen++;
        if (spiral_expect_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result value=%0d last=%0b", $time, out_value, out_last);
        end else begin
          head = spiral_expect_q.pop_front();
          if (out_value !== head.value) begin
            err_count++;
            $display("%0t: value mismatch, expected %0d, got %0d",
                     $time, head.value, out_value);
          end
          if (out_last !== head.last) begin
            err_count++;
            $display("%0t: last mismatch, expected %0b, got %0b",
                     $time, head.last, out_last);
          end
        end
      end
      // Any register write abandons a partial fill.
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_ROW_COUNT) row_reg = pwdata[DIM_W-1:0];
        else                           col_reg = pwdata[DIM_W-1:0];
        fill_count = 0;
      end
      if (start && !busy) begin
        fill_store[fill_count] = in_element;
        fill_count++;
        if (fill_count >= eff_dim(row_reg, MAX_ROWS) * eff_dim(col_reg, MAX_COLS)) begin
          fill_count = 0;
          walk_spiral();
          spirals_done++;
        end
      end
    end
    pending = spiral_expect_q.size();
  end

endmodule

[tb/sv/tb_spiral_order_matrix_scan.sv]
// Testbench top for the spiral scan block: clock, reset, item and register
// stimulus, watchdog and verdict. Depends on smos_pkg and spiral_scan_checker.
`timescale 1ns / 100ps

module tb_spiral_order_matrix_scan;
  import smos_pkg::*;

  // Cycles without any accepted item, result or register write before the
  // run is declared hung.
  localparam int QUIET_LIMIT = 1000;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [DATA_W-1:0] in_element;
  logic                    out_strobe;
  logic signed [DATA_W-1:0] out_value;
  logic                    out_last;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CFG_ADDR_W-1:0]   paddr;
  logic [CFG_DATA_W-1:0]   pwdata;
  logic [CFG_DATA_W-1:0]   prdata;
  logic                    pready;

  int err_count;
  int pending;
  int results_seen;
  int spirals_done;

  // Stimulus bookkeeping: the current counts as written, the sender's idle
  // rate in percent, and totals for the summary.
  logic [DIM_W-1:0] cur_rows;
  logic [DIM_W-1:0] cur_cols;
  int               sender_idle_pct;
  int               items_sent;
  int               settings_used;
  int               quiet_cycles;

  spiral_order_matrix_scan dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_element (in_element),
    .out_strobe (out_strobe),
    .out_value  (out_value),
    .out_last   (out_last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  spiral_scan_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_element   (in_element),
    .out_strobe   (out_strobe),
    .out_value    (out_value),
    .out_last     (out_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .err_count    (err_count),
    .pending      (pending),
    .results_seen (results_seen),
    .spirals_done (spirals_done)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The watchdog restarts whenever anything moves across a port.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (psel && penable && pwrite)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", QUIET_LIMIT);
      $display("tb_spiral_order_matrix_scan: done, errors");
      $finish;
    end
  end

  // Matrix edge length as the block applies it: zero acts as one and
  // anything above the limit acts as the limit.
  function automatic int dim_of(input logic [DIM_W-1:0] v, input int lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic int matrix_size();
    return dim_of(cur_rows, MAX_ROWS) * dim_of(cur_cols, MAX_COLS);
  endfunction

  // Counts for random settings: mostly legal, sometimes zero or too large.
  function automatic logic [DIM_W-1:0] pick_count();
    case ($urandom_range(9))
      0:       return '0;
      1:       return DIM_W'($urandom_range(MAX_ROWS + 1, 15));
      default: return DIM_W'($urandom_range(1, MAX_ROWS));
    endcase
  endfunction

  // Random element with the extremes mixed in often.
  function automatic logic signed [DATA_W-1:0] rand_element();
    case ($urandom_range(7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Two-phase register write. The upper data bits are junk half the time,
  // since only the low four bits hold the count.
  task automatic cfg_write(input logic reg_sel, input logic [DIM_W-1:0] cnt);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= ($urandom_range(1) ? ($urandom & 32'hFFFF_FFF0) : 32'h0) | 32'(cnt);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_ROW_COUNT) cur_rows = cnt;
    else                          cur_cols = cnt;
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
    cfg_write(REG_ROW_COUNT, rows);
    cfg_write(REG_COL_COUNT, cols);
    settings_used++;
  endtask

  // Present one item and hold it until the block takes it. Start is left
  // high so that a following item can go out back to back.
  task automatic send_element(input logic signed [DATA_W-1:0] v);
    int gap;
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(1, 5);
      start      <= 1'b0;
      in_element <= $urandom;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_element <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_matrix(input int n);
    for (int k = 0; k < n; k++) send_element(rand_element());
  endtask

  // Drop start, then wait until every predicted result has come out and the
  // block has settled, so that registers may be written.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One random phase. The first two settings come from a table of extreme
  // shapes; the rest are random. Now and then a matrix is left half loaded
  // and a register rewrite throws it away before a full fill follows.
  task automatic run_phase(input int idle_pct, input int item_target, input int table_base);
    logic [DIM_W-1:0] ext_rows [6];
    logic [DIM_W-1:0] ext_cols [6];
    logic [DIM_W-1:0] r;
    logic [DIM_W-1:0] c;
    int phase_end;
    int s;
    int mats;
    int part;
    ext_rows = '{4'd8, 4'd1, 4'd8, 4'd1, 4'd0, 4'd15};
    ext_cols = '{4'd8, 4'd8, 4'd1, 4'd1, 4'd15, 4'd0};
    sender_idle_pct = idle_pct;
    phase_end = items_sent + item_target;
    s = 0;
    while (items_sent < phase_end) begin
      if (s < 2) begin
        r = ext_rows[table_base + s];
        c = ext_cols[table_base + s];
      end else begin
        r = pick_count();
        c = pick_count();
      end
      wait_idle();
      if (s >= 2 && $urandom_range(3) == 0) begin
        // Change only one count; the other keeps its value.
        cfg_write(REG_ROW_COUNT, r);
        settings_used++;
      end else begin
        set_dims(r, c);
      end
      mats = $urandom_range(1, 3);
      for (int m = 0; m < mats; m++) begin
        if (matrix_size() > 1 && $urandom_range(9) == 0) begin
          part = $urandom_range(1, matrix_size() - 1);
          send_matrix(part);
          wait_idle();
          cfg_write(REG_COL_COUNT, cur_cols);
        end
        send_matrix(matrix_size());
      end
      s++;
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_element <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    items_sent      = 0;
    settings_used   = 1;
    sender_idle_pct = 26;
    cur_rows        = DIM_W'(MAX_ROWS);
    cur_cols        = DIM_W'(MAX_COLS);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: both counts start at eight, so a full 8x8 matrix
    // goes through before any register is touched.
    send_matrix(matrix_size());
    wait_idle();

    // A 1x1 matrix turns every item straight into a last result. These
    // values drive every data bit both ways, extremes included.
    set_dims(4'd1, 4'd1);
    send_element(32'sh8000_0000);
    send_element(32'sh7FFF_FFFF);
    send_element(32'sh0000_0000);
    send_element(-32'sd1);
    send_element(32'sh5555_5555);
    send_element(32'shAAAA_AAAA);
    wait_idle();

    // Counts of zero behave as one.
    set_dims(4'd0, 4'd0);
    send_element(32'sh1234_5678);
    wait_idle();

    // A single row and a single column must not be walked twice.
    set_dims(4'd1, 4'd3);
    send_matrix(3);
    wait_idle();
    set_dims(4'd3, 4'd1);
    send_matrix(3);
    wait_idle();

    // A register write in the middle of a fill restarts it from the first
    // element; the two items already taken must never show up.
    set_dims(4'd2, 4'd2);
    send_matrix(2);
    wait_idle();
    cfg_write(REG_COL_COUNT, 4'd2);
    send_matrix(4);
    wait_idle();

    // A row count above eight acts as eight.
    set_dims(4'd15, 4'd1);
    send_matrix(8);

    // Random part: sender idles often, then very often, then never.
    run_phase(26, 100, 0);
    run_phase(80, 100, 2);
    run_phase(0, 100, 4);

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Loaded %0d elements under %0d count settings; %0d spirals gave %0d results.",
             items_sent, settings_used, spirals_done, results_seen);
    if (pending != 0) begin
      $display("%0d predicted results never appeared", pending);
    end
    if (err_count == 0 && pending == 0) begin
      $display("tb_spiral_order_matrix_scan: done, clean");
    end else begin
      $display("tb_spiral_order_matrix_scan: done, errors");
    end
    $finish;
  end

endmodule

[spiral_order_matrix_scan.f]
+incdir+rtl
rtl/smos_pkg.sv
rtl/smos_store.sv
rtl/smos_walk.sv
rtl/spiral_order_matrix_scan.sv
tb/sv/spiral_scan_checker.sv
tb/sv/tb_spiral_order_matrix_scan.sv
